FILE: design/text_console_buffer_top_defines.svh
// assertion macros for the text console buffer
`ifndef TEXT_CONSOLE_BUFFER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_BUFFER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define TCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcb assertion failed");
// condition implies consequence in the next cycle
`define TCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcb assertion failed");
`else
`define TCB_ASSERT_IMP(lbl, ante, cons)
`define TCB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/tcb_pkg.sv
// shared types and constants of the text console buffer
`default_nettype none

package tcb_pkg;

    // index width that covers the largest screen (32 x 128 cells)
    localparam int IDX_W  = 13;
    localparam int CUR_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0]        BLANK_CHAR = 8'h20;
    localparam logic [7:0]        BLANK_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

    // request codes on the input tuser
    typedef enum logic [2:0] {
        KIND_PUT_CUR = 3'd0,
        KIND_PUT_AT  = 3'd1,
        KIND_MOVE_RC = 3'd2,
        KIND_MOVE_LN = 3'd3,
        KIND_CLEAR   = 3'd4,
        KIND_READ    = 3'd5
    } kind_t;

    // resolved operations handed to the back end
    typedef enum logic [2:0] {
        OP_PUT_CUR,
        OP_PUT_AT,
        OP_MOVE,
        OP_CLEAR,
        OP_READ,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [CELL_W-1:0] cell_data;   // attribute high byte, character low byte
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/tcb_front.sv
// front end: takes requests, checks ranges and resolves cell indexes
`default_nettype none

module tcb_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [39:0]        s_tdata,
    input  wire logic [2:0]         s_tuser,
    input  wire logic               q_full,
    output logic                    q_push,
    output tcb_pkg::cmd_t           q_cmd
);
    import tcb_pkg::*;

    localparam int CELLS = ROWS * COLS;

    logic [4:0]       row;
    logic [6:0]       col;
    logic [10:0]      position;
    logic [7:0]       char_code;
    logic [7:0]       attribute;
    logic             rc_ok;
    logic             pos_ok;
    logic [IDX_W-1:0] rc_idx;

    // unpack the transaction
    assign row       = s_tdata[4:0];
    assign col       = s_tdata[11:5];
    assign position  = s_tdata[22:12];
    assign char_code = s_tdata[30:23];
    assign attribute = s_tdata[38:31];

    // range checks and row-major index
    assign rc_ok  = (int'(row) < ROWS) && (int'(col) < COLS);
    assign pos_ok = int'(position) < CELLS;
    assign rc_idx = IDX_W'(row) * IDX_W'(COLS) + IDX_W'(col);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify the request
    always_comb
    begin
        q_cmd.cell_data = {attribute, char_code};
        q_cmd.idx       = rc_idx;
        q_cmd.op        = OP_REJECT;
        case (kind_t'(s_tuser))
            KIND_PUT_CUR: q_cmd.op = OP_PUT_CUR;
            KIND_PUT_AT:  q_cmd.op = rc_ok ? OP_PUT_AT : OP_REJECT;
            KIND_MOVE_RC: q_cmd.op = rc_ok ? OP_MOVE : OP_REJECT;
            KIND_MOVE_LN:
            begin
                q_cmd.op  = pos_ok ? OP_MOVE : OP_REJECT;
                q_cmd.idx = IDX_W'(position);
            end
            KIND_CLEAR:   q_cmd.op = OP_CLEAR;
            KIND_READ:    q_cmd.op = rc_ok ? OP_READ : OP_REJECT;
            default:      q_cmd.op = OP_REJECT;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/tcb_queue.sv
// two-entry command queue between front and back end
`default_nettype none

module tcb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tcb_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output tcb_pkg::cmd_t      head_cmd,
    output logic               empty
);
    import tcb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign head_cmd = entry_reg[rptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/tcb_back.sv
// back end: cell memory, cursor, scroll and clear sweeps, result register
`default_nettype none

module tcb_back #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire tcb_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               busy,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic [0:0]         m_tuser
);
    import tcb_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK
    } state_t;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0] wr_reg, wr_next;
    logic              rdv_reg, rdv_next;
    logic              m_valid_reg, m_valid_next;
    logic [CUR_W-1:0]  m_cursor_reg, m_cursor_next;
    logic              m_acc_reg, m_acc_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [7:0]        m_attr_reg, m_attr_next;

    logic              out_free;
    logic              load;
    logic              res_acc;
    logic [7:0]        res_char;
    logic [7:0]        res_attr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [CNT_W-1:0]  cur_inc;
    logic              wrap;

    assign out_free = !m_valid_reg || m_tready;
    assign cur_inc  = CNT_W'(cursor_reg) + CNT_W'(1);
    assign wrap     = cur_inc == CNT_W'(CELLS);
    assign busy     = state_reg != S_IDLE;

    // cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // operation sequencer
    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        ptr_next    = ptr_reg;
        wr_next     = wr_reg;
        rdv_next    = 1'b0;
        load        = 1'b0;
        res_acc     = 1'b0;
        res_char    = 8'd0;
        res_attr    = 8'd0;
        we          = 1'b0;
        waddr       = wr_reg;
        wdata       = BLANK_CELL;
        raddr       = q_cmd.idx[ADDR_W-1:0];
        q_pop       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_PUT_CUR:
                        begin
                            we    = 1'b1;
                            waddr = cursor_reg;
                            wdata = q_cmd.cell_data;
                            if (wrap)
                            begin
                                cursor_next = ADDR_W'(CELLS - COLS);
                                ptr_next    = CNT_W'(COLS);
                                wr_next     = '0;
                                state_next  = S_SCROLL;
                            end
                            else
                            begin
                                cursor_next = cur_inc[ADDR_W-1:0];
                                load        = 1'b1;
                                res_acc     = 1'b1;
                            end
                        end
                        OP_PUT_AT:
                        begin
                            we      = 1'b1;
                            waddr   = q_cmd.idx[ADDR_W-1:0];
                            wdata   = q_cmd.cell_data;
                            load    = 1'b1;
                            res_acc = 1'b1;
                        end
                        OP_MOVE:
                        begin
                            cursor_next = q_cmd.idx[ADDR_W-1:0];
                            load        = 1'b1;
                            res_acc     = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cursor_next = '0;
                            wr_next     = '0;
                            state_next  = S_BLANK;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load       = 1'b1;
                res_acc    = 1'b1;
                res_char   = rd_data_reg[7:0];
                res_attr   = rd_data_reg[15:8];
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read one row ahead, write the cell read in the last cycle
                raddr = ptr_reg[ADDR_W-1:0];
                if (rdv_reg)
                begin
                    we      = 1'b1;
                    waddr   = wr_reg;
                    wdata   = rd_data_reg;
                    wr_next = wr_reg + ADDR_W'(1);
                end
                if (ptr_reg != CNT_W'(CELLS))
                begin
                    rdv_next = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else if (!rdv_reg)
                begin
                    state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                we = 1'b1;
                if (wr_reg == ADDR_W'(CELLS - 1))
                begin
                    load       = 1'b1;
                    res_acc    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_next = wr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register next values
    always_comb
    begin
        m_valid_next  = (m_valid_reg && !m_tready) || load;
        m_cursor_next = m_cursor_reg;
        m_acc_next    = m_acc_reg;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        if (load)
        begin
            m_cursor_next = CUR_W'(cursor_next);
            m_acc_next    = res_acc;
            m_char_next   = res_char;
            m_attr_next   = res_attr;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cursor_reg   <= '0;
            ptr_reg      <= '0;
            wr_reg       <= '0;
            rdv_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_cursor_reg <= '0;
            m_acc_reg    <= 1'b0;
            m_char_reg   <= 8'd0;
            m_attr_reg   <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            ptr_reg      <= ptr_next;
            wr_reg       <= wr_next;
            rdv_reg      <= rdv_next;
            m_valid_reg  <= m_valid_next;
            m_cursor_reg <= m_cursor_next;
            m_acc_reg    <= m_acc_next;
            m_char_reg   <= m_char_next;
            m_attr_reg   <= m_attr_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_attr_reg, m_char_reg, m_cursor_reg};
    assign m_tuser  = m_acc_reg;

endmodule

`default_nettype wire

FILE: design/text_console_buffer_top.sv
// top level of the text console buffer
// Usage:
//   Requests enter on the s_ channel: tuser carries the request kind, tdata the
//   row, column, linear position, character and attribute. Every request gives
//   exactly one result on the m_ channel: tdata holds the cursor and the read
//   character and attribute, tuser the accepted flag.
//   An accepted put, move or rejected request passes the queue, then the
//   result register; a cell read also passes the registered read port.
//   Throughput: one put, move or rejected request per cycle while the
//   receiver takes each result; a read holds the back end in S_READ. A
//   clear walks every cell, one write per cycle; a put that steps past the
//   last cell scrolls, copying one cell per cycle and then blanking the last
//   row. The single write port of the cell memory sets these rates.
//   A two-entry queue decouples the input from the back end, so up to two
//   requests are taken while a sweep runs or the result waits.
//   Reset clears the cursor, the queue and the result register; the cell
//   contents stay undefined until written by a put or a clear.
//   When the receiver stalls, the result holds and the queue fills, then
//   s_tready drops.
`default_nettype none

`include "text_console_buffer_top_defines.svh"

module text_console_buffer_top #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // row, col, position, char_code, attribute, pad
    input  wire logic [2:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // cursor, read_char, read_attribute, pad
    output logic [0:0]       m_tuser    // accepted
);
    import tcb_pkg::*;

    localparam int CELLS = ROWS * COLS;

    logic q_full;
    logic q_push;
    cmd_t push_cmd;
    logic q_empty;
    logic q_pop;
    cmd_t head_cmd;
    logic busy;

    // request classification
    tcb_front #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // command queue
    tcb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .head_cmd(head_cmd),
        .empty   (q_empty)
    );

    // execution and results
    tcb_back #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .busy    (busy),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // checks
    `TCB_ASSERT_IMP(a_reject_no_data, m_tvalid && !m_tuser[0], m_tdata[26:11] == 16'd0)
    `TCB_ASSERT_IMP(a_no_pop_when_busy, busy, !q_pop)
    `TCB_ASSERT_NEXT(a_read_holds_back, q_pop && (head_cmd.op == OP_READ), busy && !q_pop)
    `TCB_ASSERT_IMP(a_cursor_range, m_tvalid && (CELLS <= 2048), int'(m_tdata[10:0]) < CELLS)

endmodule

`default_nettype wire
